// ===== hw/rtl/icds_pkg.sv =====
`default_nettype none

package icds_pkg;

    // input item kind, carried on s_tuser
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_NEW   = 2'd2;

    localparam int FUNC_W      = 2;
    localparam int END_W       = 24;
    localparam int GPOS_W      = 25;
    localparam int DEPTH_W     = 7;
    localparam int BASE_W      = 24;
    localparam int STRIDE_W    = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 7'd127;

    // register select, paddr[2]
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_STRIDE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
        logic divisible;
    } icds_rem_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/icds_rem.sv =====
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle, MSB first.
module icds_rem #(
    parameter int DW = 25
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [DW-1:0]                 dividend,
    input  wire logic [icds_pkg::STRIDE_W-1:0] divisor,
    output icds_pkg::icds_rem_stat_t           stat
);
    import icds_pkg::*;

    localparam int SW = $clog2(DW + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STRIDE_W-1:0] rem_reg, rem_next;
    logic [DW-1:0]       num_reg, num_next;
    logic [STRIDE_W-1:0] div_reg, div_next;
    logic [SW-1:0]       step_reg, step_next;

    logic [STRIDE_W:0]   trial;
    logic [STRIDE_W:0]   diff;
    logic                ge;

    always_comb begin
        trial = {rem_reg, num_reg[DW-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            num_next  = dividend;
            div_next  = divisor;
            step_next = SW'(DW);
        end else if (busy_reg) begin
            rem_next  = ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
            num_next  = {num_reg[DW-2:0], 1'b0};
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        div_reg  <= div_next;
        step_reg <= step_next;
    end

    always_comb begin
        stat.busy      = busy_reg;
        stat.done      = done_reg;
        stat.divisible = (rem_reg == '0);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/interval_coverage_depth_sweep_unit.sv =====
`default_nettype none
// Add-read and new-sequence transactions: ready again on the next cycle.
// Close-position runs the remainder unit on the GW-bit position (GW = max(POS_WIDTH,24)+1,
// 25 by default), then a result state and a sweep over the active entries. A report is
// issued only for a stride-divisible position, and waits while an earlier one is unread.
// aresetn is synchronous: empties the active set, clears position, overflow and the offset
// register, stride to 1. No clearing pass: entries past the fill count are never read.
module interval_coverage_depth_sweep_unit #(
    parameter int MAX_ACTIVE = 64,
    parameter int POS_WIDTH  = 24
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icds_pkg::APB_AW-1:0]      paddr,
    input  wire logic [icds_pkg::APB_DW-1:0]      pwdata,
    output logic      [icds_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [icds_pkg::IN_TDATA_W-1:0]  s_tdata,  // [23:0] right_end
    input  wire logic [icds_pkg::FUNC_W-1:0]      s_tuser,  // [1:0] func
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [icds_pkg::OUT_TDATA_W-1:0] m_tdata   // [24:0] global_position,
                                                            // [31:25] depth,
                                                            // [32] overflow_seen
);
    import icds_pkg::*;

    localparam int IW = $clog2(MAX_ACTIVE);
    localparam int CW = $clog2(MAX_ACTIVE + 1);
    localparam int GW = ((POS_WIDTH > BASE_W) ? POS_WIDTH : BASE_W) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [BASE_W-1:0]      base_reg;
    logic [STRIDE_W-1:0]    stride_reg;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   divisible_reg, divisible_next;
    logic [CW-1:0]          sw_idx_reg, sw_idx_next;
    logic [CW-1:0]          wr_idx_reg, wr_idx_next;
    logic                   pend_reg, pend_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // end-point RAM, kept compact: entries below count_reg are live
    logic [POS_WIDTH-1:0]   end_mem [MAX_ACTIVE];
    logic [POS_WIDTH-1:0]   rd_data_reg;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [POS_WIDTH-1:0]   mem_wdata;

    logic                   cfg_wr;
    logic                   accept;
    logic                   div_start;
    logic [GW-1:0]          gpos;
    logic [STRIDE_W-1:0]    divisor;
    logic [POS_WIDTH+END_W-1:0] end_ext;
    logic [POS_WIDTH-1:0]   new_end;
    logic [CW+DEPTH_W-1:0]  cnt_ext;
    logic [DEPTH_W-1:0]     depth;
    logic                   out_free;
    icds_rem_stat_t         rem_stat;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == REG_STRIDE) begin
            prdata = {{(APB_DW-STRIDE_W){1'b0}}, stride_reg};
        end else begin
            prdata = {{(APB_DW-BASE_W){1'b0}}, base_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            stride_reg <= STRIDE_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BASE) begin
                base_reg <= pwdata[BASE_W-1:0];
            end else begin
                stride_reg <= pwdata[STRIDE_W-1:0];
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign end_ext = {{POS_WIDTH{1'b0}}, s_tdata[END_W-1:0]};
    assign new_end = end_ext[POS_WIDTH-1:0];
    assign gpos    = GW'(pos_reg) + GW'(base_reg);
    assign divisor = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;

    assign cnt_ext  = {{DEPTH_W{1'b0}}, count_reg};
    assign depth    = (cnt_ext > (CW+DEPTH_W)'(DEPTH_MAX)) ? DEPTH_MAX : cnt_ext[DEPTH_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    icds_rem #(
        .DW (GW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (gpos),
        .divisor  (divisor),
        .stat     (rem_stat)
    );

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        divisible_next = divisible_reg;
        sw_idx_next    = sw_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IW-1:0];
        mem_wdata      = new_end;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        FUNC_ADD: begin
                            if (count_reg < CW'(MAX_ACTIVE)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_CLOSE: begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        FUNC_NEW: begin
                            count_next = '0;
                            pos_next   = '0;
                            ovf_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    divisible_next = rem_stat.divisible;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!divisible_reg || out_free) begin
                    if (divisible_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {{(OUT_TDATA_W-GPOS_W-DEPTH_W-1){1'b0}},
                                         ovf_reg, depth, gpos[GPOS_W-1:0]};
                    end
                    pos_next    = pos_reg + POS_WIDTH'(1);
                    sw_idx_next = '0;
                    wr_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // read one entry a cycle, write survivors back packed from the bottom
                if (sw_idx_reg < count_reg) begin
                    sw_idx_next = sw_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (rd_data_reg >= pos_reg)) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_idx_reg[IW-1:0];
                    mem_wdata   = rd_data_reg;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if ((sw_idx_reg == count_reg) && !pend_reg) begin
                    count_next = wr_idx_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            end_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= end_mem[sw_idx_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        divisible_reg <= divisible_next;
        sw_idx_reg    <= sw_idx_next;
        wr_idx_reg    <= wr_idx_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ACTIVE))
        else $error("active count beyond capacity");

    a_close_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == FUNC_CLOSE)) |=> (state_reg == ST_DIV) && rem_stat.busy)
        else $error("close transaction did not start remainder unit");

    a_sweep_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (wr_idx_reg <= sw_idx_reg))
        else $error("sweep write index overtook read index");

    a_ovf_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> (count_reg == CW'(MAX_ACTIVE)))
        else $error("overflow flagged with free entries");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder result outside divide state");

endmodule

`default_nettype wire
